// ===== rtl/core/sorted_alarm_timer_queue_assert.svh =====
// assertion macros for the sorted alarm timer queue
// no dependencies; define ASSERT_OFF to drop all checks
`ifndef SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH
`define SORTED_ALARM_TIMER_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define SATQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SATQ_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SATQ_ASSERT(label, clk, rst_n, prop, msg)
`define SATQ_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/core/satq_pkg.sv =====
// types and constants shared by the sorted alarm timer queue
// no dependencies
package satq_pkg;
    localparam int QueueDepth = 16;
    localparam int AlarmIds   = 256;
    localparam int MaxFires   = 16;
    localparam int PosW       = $clog2(QueueDepth);
    localparam int CntW       = $clog2(QueueDepth + 1);
    localparam int FireW      = $clog2(MaxFires + 1);
    localparam int CmdDepth   = 2;

    localparam logic [1:0] REQ_SET   = 2'd0;
    localparam logic [1:0] REQ_UNSET = 2'd1;
    localparam logic [1:0] REQ_RESET = 2'd2;
    localparam logic [1:0] REQ_TICK  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOTQ    = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_ALREADY = 2'd3;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FIRED  = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  alarm_id;
        logic [63:0] wake_time;
        logic [63:0] now_time;
    } req_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  fired_id;
        logic [1:0]  status_code;
        logic        was_removed;
        logic [63:0] next_deadline;
        logic        timer_armed;
        logic        last_result;
    } res_t;

    // classified command from front to back
    typedef struct packed {
        logic        do_tick;
        logic        do_remove;
        logic        do_insert;
        logic        id_valid;
        logic [1:0]  req_type;
        logic [7:0]  alarm_id;
        logic [63:0] key_time;
    } cmd_t;
endpackage

// ===== rtl/core/satq_front.sv =====
// front part: accepts requests, classifies them, buffers commands
// depends on satq_pkg
module satq_front (
    input  logic              clk,
    input  logic              rst_n,
    input  satq_pkg::req_t    req,
    input  logic              push,
    output logic              full,
    output satq_pkg::cmd_t    cmd,
    output logic              cmd_valid,
    input  logic              cmd_take
);
    localparam int PW = $clog2(satq_pkg::CmdDepth);
    satq_pkg::cmd_t   buf_reg [satq_pkg::CmdDepth];
    logic [PW-1:0]    wr_reg, rd_reg;
    logic [PW:0]      cnt_reg;
    satq_pkg::cmd_t   c;
    logic             do_push, do_pop;

    always_comb
    begin
        c.id_valid  = ({24'd0, req.alarm_id} < 32'(satq_pkg::AlarmIds));
        c.req_type  = req.req_type;
        c.alarm_id  = req.alarm_id;
        c.do_tick   = (req.req_type == satq_pkg::REQ_TICK);
        c.do_remove = c.id_valid && (req.req_type == satq_pkg::REQ_UNSET ||
                                     req.req_type == satq_pkg::REQ_RESET);
        c.do_insert = c.id_valid && (req.req_type == satq_pkg::REQ_SET ||
                                     req.req_type == satq_pkg::REQ_RESET);
        c.key_time  = c.do_tick ? req.now_time : req.wake_time;
    end

    assign full      = (cnt_reg == (PW+1)'(satq_pkg::CmdDepth));
    assign do_push   = push && !full;
    assign cmd_valid = (cnt_reg != '0);
    assign do_pop    = cmd_take && cmd_valid;
    assign cmd       = buf_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            buf_reg[wr_reg] <= c;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg <= '0; rd_reg <= '0; cnt_reg <= '0;
        end
        else
        begin
            if (do_push) wr_reg <= wr_reg + 1'b1;
            if (do_pop)  rd_reg <= rd_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(do_push) - (PW+1)'(do_pop);
        end
    end
endmodule

// ===== rtl/core/satq_back.sv =====
// back part: shift-insert sorted array, id flags, result register
// depends on satq_pkg
module satq_back (
    input  logic              clk,
    input  logic              rst_n,
    input  satq_pkg::cmd_t    cmd,
    input  logic              cmd_valid,
    output logic              cmd_take,
    output satq_pkg::res_t    res,
    output logic              empty,
    input  logic              pop
);
    localparam int D  = satq_pkg::QueueDepth;
    localparam int PW = satq_pkg::PosW;
    localparam int CW = satq_pkg::CntW;
    localparam int IW = $clog2(satq_pkg::AlarmIds);

    typedef enum logic [2:0] {S_IDLE, S_REMOVE, S_INSERT, S_FIRE, S_STATUS} state_t;

    state_t         state_reg;
    logic [63:0]    time_reg  [D];
    logic [7:0]     owner_reg [D];
    logic [CW-1:0]  count_reg;
    logic [satq_pkg::AlarmIds-1:0] flag_reg;
    logic [satq_pkg::FireW-1:0]    fires_reg;
    satq_pkg::cmd_t cur_reg;
    logic [1:0]     status_reg;
    logic           removed_reg;
    satq_pkg::res_t out_reg;
    logic           out_valid_reg;

    logic [IW-1:0]  cid;
    logic           queued;
    logic           is_full;
    logic [D-1:0]   match, le;
    logic           can_emit;
    logic [63:0]    head_time;
    logic           armed;

    assign cid      = cur_reg.alarm_id[IW-1:0];
    assign queued   = flag_reg[cid];
    assign is_full  = (count_reg >= CW'(D));
    assign empty    = !out_valid_reg;
    assign res      = out_reg;
    assign can_emit = !out_valid_reg || pop;
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign armed    = (count_reg != '0);
    assign head_time = armed ? time_reg[0] : 64'd0;

    // per-slot compares, independent across slots
    always_comb
    begin
        for (int i = 0; i < D; i++)
        begin
            match[i] = (CW'(i) < count_reg) && (owner_reg[i] == cur_reg.alarm_id);
            le[i]    = (CW'(i) < count_reg) && (time_reg[i] <= cur_reg.key_time);
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REMOVE && cur_reg.do_remove && queued)
        begin
            // close the gap left by the matched slot
            for (int i = 0; i < D - 1; i++)
                if ((match & ((D'(1) << (i + 1)) - D'(1))) != '0)
                begin
                    time_reg[i]  <= time_reg[i+1];
                    owner_reg[i] <= owner_reg[i+1];
                end
        end
        else if (state_reg == S_INSERT && cur_reg.do_insert && !queued && !is_full)
        begin
            if (!le[0])
            begin
                time_reg[0]  <= cur_reg.key_time;
                owner_reg[0] <= cur_reg.alarm_id;
            end
            for (int i = 1; i < D; i++)
                if (!le[i])
                begin
                    if (!le[i-1])
                    begin
                        time_reg[i]  <= time_reg[i-1];
                        owner_reg[i] <= owner_reg[i-1];
                    end
                    else
                    begin
                        time_reg[i]  <= cur_reg.key_time;
                        owner_reg[i] <= cur_reg.alarm_id;
                    end
                end
        end
        else if (state_reg == S_FIRE && can_emit && armed &&
                 fires_reg < satq_pkg::FireW'(satq_pkg::MaxFires) &&
                 time_reg[0] <= cur_reg.key_time)
        begin
            for (int i = 0; i < D - 1; i++)
            begin
                time_reg[i]  <= time_reg[i+1];
                owner_reg[i] <= owner_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
            fires_reg     <= '0;
            status_reg    <= satq_pkg::ST_OK;
            removed_reg   <= 1'b0;
            cur_reg       <= '0;
            out_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (cmd_valid)
                    begin
                        cur_reg     <= cmd;
                        fires_reg   <= '0;
                        removed_reg <= 1'b0;
                        status_reg  <= satq_pkg::ST_OK;
                        state_reg   <= cmd.do_tick ? S_FIRE : S_REMOVE;
                    end
                S_REMOVE:
                begin
                    if (cur_reg.do_remove && queued)
                    begin
                        if ((match) != '0)
                            count_reg <= count_reg - 1'b1;
                        flag_reg[cid] <= 1'b0;
                        removed_reg   <= 1'b1;
                    end
                    state_reg <= S_INSERT;
                end
                S_INSERT:
                begin
                    // remove already ran, so queued is the post-unset view
                    if (!cur_reg.id_valid)
                        status_reg <= (cur_reg.req_type == satq_pkg::REQ_UNSET) ?
                                      satq_pkg::ST_NOTQ : satq_pkg::ST_FULL;
                    else if (cur_reg.req_type == satq_pkg::REQ_UNSET)
                        status_reg <= removed_reg ? satq_pkg::ST_OK : satq_pkg::ST_NOTQ;
                    else if (queued)
                        status_reg <= satq_pkg::ST_ALREADY;
                    else if (is_full)
                        status_reg <= satq_pkg::ST_FULL;
                    else
                    begin
                        count_reg     <= count_reg + 1'b1;
                        flag_reg[cid] <= 1'b1;
                    end
                    state_reg <= S_STATUS;
                end
                S_FIRE:
                    if (can_emit)
                    begin
                        if (armed && fires_reg < satq_pkg::FireW'(satq_pkg::MaxFires) &&
                            time_reg[0] <= cur_reg.key_time)
                        begin
                            out_reg.result_kind   <= satq_pkg::KIND_FIRED;
                            out_reg.fired_id      <= owner_reg[0];
                            out_reg.status_code   <= satq_pkg::ST_OK;
                            out_reg.was_removed   <= 1'b0;
                            out_reg.next_deadline <= (count_reg > CW'(1)) ?
                                                     time_reg[1] : 64'd0;
                            out_reg.timer_armed   <= (count_reg > CW'(1));
                            out_reg.last_result   <= 1'b0;
                            out_valid_reg         <= 1'b1;
                            count_reg             <= count_reg - 1'b1;
                            if ({24'd0, owner_reg[0]} < 32'(satq_pkg::AlarmIds))
                                flag_reg[owner_reg[0][IW-1:0]] <= 1'b0;
                            fires_reg <= fires_reg + 1'b1;
                        end
                        else
                            state_reg <= S_STATUS;
                    end
                S_STATUS:
                    if (can_emit)
                    begin
                        out_reg.result_kind   <= satq_pkg::KIND_STATUS;
                        out_reg.fired_id      <= cur_reg.alarm_id;
                        out_reg.status_code   <= status_reg;
                        out_reg.was_removed   <= removed_reg;
                        out_reg.next_deadline <= head_time;
                        out_reg.timer_armed   <= armed;
                        out_reg.last_result   <= 1'b1;
                        out_valid_reg         <= 1'b1;
                        state_reg             <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/core/sorted_alarm_timer_queue.sv =====
// Sorted alarm timer queue, top level: up to 16 alarms kept sorted by
// 64-bit wake time in a shift-insert register array, equal times in arrival
// order. A set, unset or reset passes through the back-end states take,
// remove, insert and status; a tick passes through take, one fire step per
// fired alarm (at most 16 per tick), a step that finds no more expired alarms,
// and status. Fire and status steps wait while the single result register
// still holds an unpopped result. A two-entry command queue lets requests
// be pushed while the back end works. No clearing pass is needed after reset.
// depends on satq_pkg, satq_front, satq_back, sorted_alarm_timer_queue_assert.svh
`include "sorted_alarm_timer_queue_assert.svh"
module sorted_alarm_timer_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  satq_pkg::req_t    req,
    input  logic              push,
    output logic              full,
    output satq_pkg::res_t    res,
    output logic              empty,
    input  logic              pop
);
    satq_pkg::cmd_t cmd;
    logic           cmd_valid, cmd_take;

    satq_front u_front (
        .clk(clk), .rst_n(rst_n), .req(req), .push(push), .full(full),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_take(cmd_take)
    );

    satq_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_take(cmd_take), .res(res), .empty(empty), .pop(pop)
    );

    `SATQ_ASSERT(a_take_needs_cmd, clk, rst_n, cmd_take |-> cmd_valid, "take without command")
    `SATQ_ASSERT(a_res_hold, clk, rst_n, (!empty && !pop) |=> $stable(res), "result changed while waiting")
    `SATQ_ASSERT(a_fired_not_last, clk, rst_n, (!empty && res.result_kind) |-> !res.last_result, "fired marked last")
endmodule
